FILE: src/sitda_pkg.sv
// Shared constants and types for the signed integer to decimal text unit.
package sitda_pkg;

    // Width of the integer that is converted, and number of decimal digit slots
    localparam int VALUE_WIDTH = 64;
    localparam int MAX_DIGITS  = 19;

    // Magnitude bits shifted into the digit register per sequencer cycle
    localparam int STEP_BITS = 4;
    localparam int ITERS     = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int ITER_W    = (ITERS > 1) ? $clog2(ITERS) : 1;
    localparam int MAG_W     = ITERS * STEP_BITS;

    // Digit slot index and digit count widths
    localparam int DIG_W = $clog2(MAX_DIGITS);
    localparam int CNT_W = $clog2(MAX_DIGITS + 1);

    // Result field widths
    localparam int CHAR_W  = 8;
    localparam int INDEX_W = 5;

    // Characters
    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

    // Shift-and-add-three correction: a digit of five or more gets three added
    localparam logic [3:0] ADJ_LIMIT = 4'd5;
    localparam logic [3:0] ADJ_ADD   = 4'd3;

    // Decimal digits, least significant in slot 0
    typedef logic [MAX_DIGITS-1:0][3:0] bcd_t;

endpackage

FILE: src/signed_int_to_decimal_ascii_unit.sv
// A request is converted STEP_BITS magnitude bits per cycle in the convert state, then a
// locate state finds the leading digit, then one character is emitted per cycle.
// The sequencer stays busy until the last character is emitted, so a new request is taken
// only after the previous string is complete.
// Results cannot be stalled. Asynchronous active-low reset returns the sequencer to idle.
module signed_int_to_decimal_ascii_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [63:0]                    value,
    output logic                                  strobe,
    output logic [sitda_pkg::CHAR_W-1:0]          text_char,
    output logic [sitda_pkg::INDEX_W-1:0]         char_index,
    output logic                                  last_char
);
    import sitda_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_LOCATE,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [ITER_W-1:0]      iter_reg;
    logic [MAG_W-1:0]       mag_reg;
    bcd_t                   bcd_reg;
    logic                   overflow_reg;
    logic                   neg_reg;
    logic [DIG_W-1:0]       digit_idx_reg;
    logic [INDEX_W-1:0]     pos_reg;
    logic                   strobe_reg;
    logic [CHAR_W-1:0]      char_reg;
    logic [INDEX_W-1:0]     index_reg;
    logic                   last_reg;

    logic [VALUE_WIDTH-1:0] raw;
    logic                   raw_neg;
    logic [VALUE_WIDTH-1:0] raw_mag;
    bcd_t                   bcd_next;
    logic                   step_carry;
    logic [CNT_W-1:0]       lead_count;
    logic [CNT_W-1:0]       digit_count;
    logic [CNT_W-1:0]       top_slot;
    logic [3:0]             cur_digit;

    // Form the magnitude of the request as an unsigned quantity
    assign raw     = value[VALUE_WIDTH-1:0];
    assign raw_neg = raw[VALUE_WIDTH-1];
    assign raw_mag = raw_neg ? (~raw + VALUE_WIDTH'(1)) : raw;

    // Shared conversion unit, fed from the top of the magnitude register
    sitda_bcd_step u_step (
        .bcd      (bcd_reg),
        .bits     (mag_reg[MAG_W-1 -: STEP_BITS]),
        .bcd_next (bcd_next),
        .carry    (step_carry)
    );

    // Find the most significant non-zero digit; keep at least one digit
    always_comb
    begin
        lead_count = '0;
        for (int i = 0; i < MAX_DIGITS; i++)
        begin
            if (bcd_reg[i] != 4'd0)
            begin
                lead_count = CNT_W'(i + 1);
            end
        end
        priority if (overflow_reg)
        begin
            digit_count = CNT_W'(MAX_DIGITS);
        end
        else if (lead_count == '0)
        begin
            digit_count = CNT_W'(1);
        end
        else
        begin
            digit_count = lead_count;
        end
        top_slot = digit_count - CNT_W'(1);
    end

    assign cur_digit = bcd_reg[digit_idx_reg];

    // Sequencer with registered results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            mag_reg       <= '0;
            bcd_reg       <= '0;
            overflow_reg  <= 1'b0;
            neg_reg       <= 1'b0;
            digit_idx_reg <= '0;
            pos_reg       <= '0;
            strobe_reg    <= 1'b0;
            char_reg      <= '0;
            index_reg     <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        mag_reg      <= MAG_W'(raw_mag);
                        neg_reg      <= raw_neg;
                        bcd_reg      <= '0;
                        overflow_reg <= 1'b0;
                        iter_reg     <= '0;
                        state_reg    <= ST_CONVERT;
                    end
                end
                ST_CONVERT:
                begin
                    bcd_reg      <= bcd_next;
                    overflow_reg <= overflow_reg | step_carry;
                    mag_reg      <= mag_reg << STEP_BITS;
                    iter_reg     <= iter_reg + ITER_W'(1);
                    if (iter_reg == ITER_W'(ITERS - 1))
                    begin
                        state_reg <= ST_LOCATE;
                    end
                end
                ST_LOCATE:
                begin
                    digit_idx_reg <= top_slot[DIG_W-1:0];
                    pos_reg       <= '0;
                    state_reg     <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    strobe_reg <= 1'b1;
                    index_reg  <= pos_reg;
                    pos_reg    <= pos_reg + INDEX_W'(1);
                    if (neg_reg)
                    begin
                        // Emit the sign first, then drop it
                        char_reg <= MINUS_CHAR;
                        last_reg <= 1'b0;
                        neg_reg  <= 1'b0;
                    end
                    else
                    begin
                        char_reg <= ZERO_CHAR + CHAR_W'(cur_digit);
                        last_reg <= (digit_idx_reg == '0);
                        if (digit_idx_reg == '0)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            digit_idx_reg <= digit_idx_reg - DIG_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign text_char  = char_reg;
    assign char_index = index_reg;
    assign last_char  = last_reg;

    // A taken request always starts a conversion
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken without starting a conversion");

    // Characters of one string come on consecutive cycles with rising positions
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_char |=> strobe && (char_index == $past(char_index) + 5'd1))
        else $error("character run broken or position skipped");

    // Nothing follows the final character straight away
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_char |=> !strobe)
        else $error("character emitted after the final character");

    // No characters while the digits are being formed
    a_quiet_convert: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CONVERT) |-> !strobe)
        else $error("character emitted during conversion");

endmodule

FILE: src/sitda_bcd_step.sv
// Shared shift-and-add-three unit: moves STEP_BITS binary bits into the decimal digits.
module sitda_bcd_step (
    input  sitda_pkg::bcd_t                   bcd,
    input  logic [sitda_pkg::STEP_BITS-1:0]   bits,
    output sitda_pkg::bcd_t                   bcd_next,
    output logic                              carry
);
    import sitda_pkg::*;

    bcd_t work;
    logic out_bit;

    // Apply one correction and one left shift per incoming bit, msb first
    always_comb
    begin
        work    = bcd;
        carry   = 1'b0;
        out_bit = 1'b0;
        for (int s = 0; s < STEP_BITS; s++)
        begin
            for (int d = 0; d < MAX_DIGITS; d++)
            begin
                if (work[d] >= ADJ_LIMIT)
                begin
                    work[d] = work[d] + ADJ_ADD;
                end
            end
            out_bit = work[MAX_DIGITS-1][3];
            work    = {work[MAX_DIGITS-1][2:0], work[MAX_DIGITS-2:0], bits[STEP_BITS-1-s]};
            carry   = carry | out_bit;
        end
        bcd_next = work;
    end

endmodule

FILE: tb/tb.sv
// Self-checking bench for the signed integer to decimal ASCII text unit.
module tb;
    import sitda_pkg::*;

    // One expected character of the decimal text
    typedef struct packed {
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
        logic               last;
    } text_char_rec_t;

    // One request waiting to be sent; drain holds it until all text has come back
    typedef struct {
        logic [63:0] value;
        bit          drain;
    } request_t;

    localparam int N_RANDOM    = 188;
    localparam int TAIL_CYCLES = 45;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    logic [63:0] value   = '0;
    logic        busy;
    logic        strobe;
    logic [CHAR_W-1:0]  text_char;
    logic [INDEX_W-1:0] char_index;
    logic               last_char;

    request_t       requests_to_send[$];
    text_char_rec_t expected_chars[$];

    int n_total        = 0;
    int n_directed     = 0;
    int n_values_sent  = 0;
    int n_negative     = 0;
    int n_chars_seen   = 0;
    int n_mismatches   = 0;

    signed_int_to_decimal_ascii_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .value      (value),
        .strobe     (strobe),
        .text_char  (text_char),
        .char_index (char_index),
        .last_char  (last_char)
    );

    // Free-running clock, period 12
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Work out the characters that one request must produce and queue them
    task automatic predict_text(input logic [63:0] v);
        logic [63:0] mask;
        logic [63:0] raw;
        logic [63:0] mag;
        logic        neg;
        logic [3:0]  digs [MAX_DIGITS];
        int          ndig;
        int          pos;
        mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
        raw  = v & mask;
        neg  = raw[VALUE_WIDTH-1];
        mag  = neg ? ((~raw + 64'd1) & mask) : raw;
        ndig = 0;
        // Peel off digits, least significant first; drop any beyond the slot count
        while (ndig == 0 || (mag != 0 && ndig < MAX_DIGITS))
        begin
            digs[ndig] = 4'(mag % 64'd10);
            mag        = mag / 64'd10;
            ndig++;
        end
        pos = 0;
        if (neg)
        begin
            expected_chars.push_back('{MINUS_CHAR, INDEX_W'(pos), 1'b0});
            pos++;
            n_negative++;
        end
        for (int i = ndig - 1; i >= 0; i--)
        begin
            expected_chars.push_back('{ZERO_CHAR + CHAR_W'(digs[i]), INDEX_W'(pos), i == 0});
            pos++;
        end
    endtask

    // Driver: record accepted requests, then present the next one or idle
    always @(posedge clk or negedge rst_n)
    begin : drive
        bit idle_now;
        bit may_send;
        if (!rst_n)
        begin
            start <= 1'b0;
            value <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                predict_text(value);
                n_values_sent++;
            end
            if (!start || !busy)
            begin
                // Keep a stretch with no idle gaps in the middle of the run
                if (n_values_sent >= 90 && n_values_sent < 140)
                    idle_now = 1'b0;
                else
                    idle_now = ($urandom_range(99, 0) < 35);
                may_send = requests_to_send.size() != 0 && !idle_now;
                if (may_send && requests_to_send[0].drain)
                    may_send = !strobe && expected_chars.size() == 0;
                if (may_send)
                begin
                    start <= 1'b1;
                    value <= requests_to_send[0].value;
                    requests_to_send.pop_front();
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each emitted character with the oldest expectation
    always @(posedge clk)
    begin : check
        text_char_rec_t want;
        if (rst_n && strobe)
        begin
            n_chars_seen++;
            if (expected_chars.size() == 0)
            begin
                n_mismatches++;
                if (n_mismatches <= 10)
                    $display("unexpected character: char %h index %0d last %b",
                             text_char, char_index, last_char);
            end
            else
            begin
                want = expected_chars.pop_front();
                if (text_char !== want.ch || char_index !== want.idx || last_char !== want.last)
                begin
                    n_mismatches++;
                    if (n_mismatches <= 10)
                        $display("mismatch: expected char %h index %0d last %b, got %h %0d %b",
                                 want.ch, want.idx, want.last,
                                 text_char, char_index, last_char);
                end
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        logic [63:0] directed_values[$];
        logic [63:0] mag;
        logic [63:0] p;
        int          k;
        directed_values = '{
            64'd0, 64'd1, -64'sd1, 64'd9, 64'd10, -64'sd10, 64'd99, 64'd100, -64'sd100,
            64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001,
            64'd999_999_999_999_999_999, 64'd1_000_000_000_000_000_000,
            -64'sd1_000_000_000_000_000_000, 64'd1_234_567_890_123_456_789,
            -64'sd987_654_321, 64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
            64'hFFFF_FFFF_0000_0000, 64'd4_294_967_296, 64'd5
        };
        foreach (directed_values[i])
            requests_to_send.push_back('{directed_values[i], 1'b0});
        n_directed = directed_values.size();

        for (int n = 0; n < N_RANDOM; n++)
        begin
            case ($urandom_range(3, 0))
                0: mag = {$urandom, $urandom};
                1:
                begin
                    // Random length from one to nineteen digits
                    k = $urandom_range(19, 1);
                    p = 64'd1;
                    repeat (k) p = p * 64'd10;
                    mag = {$urandom, $urandom} % p;
                end
                2:
                begin
                    // Either side of a power of ten
                    k = $urandom_range(18, 0);
                    p = 64'd1;
                    repeat (k) p = p * 64'd10;
                    mag = p + 64'($urandom_range(2, 0)) - 64'd1;
                end
                default: mag = 64'($urandom_range(999, 0));
            endcase
            if ($urandom_range(1, 0))
                mag = -mag;
            requests_to_send.push_back('{mag, (n % 50) == 0});
        end
        n_total = requests_to_send.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (n_values_sent != n_total)
            @(posedge clk);
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("converted %0d integers (%0d directed, %0d negative), %0d characters checked",
                 n_values_sent, n_directed, n_negative, n_chars_seen);
        $display("mismatches: %0d", n_mismatches);
        if (n_mismatches == 0 && expected_chars.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
